@@ src/mer_pkg.sv @@
// ----------------------------------------------------------------------------
// mer_pkg: shared types and constants of the midpoint ellipse rasterizer
// configuration register indexes, item op codes, datapath command and status
// ----------------------------------------------------------------------------
package mer_pkg;

  localparam int CENTER_W  = 10;
  localparam int CFG_IDX_W = 1;

  localparam logic [CENTER_W-1:0] CENTER_X_RST = 10'd320;
  localparam logic [CENTER_W-1:0] CENTER_Y_RST = 10'd240;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_CENTER_X = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_CENTER_Y = 1'b1;

  // item op codes
  localparam logic OP_START   = 1'b0;
  localparam logic OP_ADVANCE = 1'b1;

  // multiplier operand pairs
  typedef enum logic [3:0] {
    MUL_AA,
    MUL_BB,
    MUL_ASQ_B,
    MUL_ASQ_2YM1,
    MUL_BSQ_XP1,
    MUL_BSQ_2XP3,
    MUL_ASQ_2M2Y,
    MUL_2XP1_SQ,
    MUL_BSQ_TMP,
    MUL_YM1_SQ,
    MUL_ASQ_TMP,
    MUL_ASQ_BSQ,
    MUL_BSQ_2XP2,
    MUL_ASQ_3M2Y
  } mul_sel_e;

  // where the registered product goes, in the cycle after the command
  typedef enum logic [3:0] {
    WB_NONE,
    WB_ASQ,
    WB_BSQ,
    WB_TMP,
    WB_CMP,
    WB_D_INIT,
    WB_D_LOAD,
    WB_D_ADD4,
    WB_D_SUB4
  } wb_sel_e;

  typedef struct packed {
    logic     load_axes;
    mul_sel_e mul;
    wb_sel_e  wb;
    logic     init_offsets;
    logic     step_x;
    logic     step_y;
    logic     emit;
    logic     emit_idle;
    logic     emit_region;
  } cmd_t;

  typedef struct packed {
    logic d_neg;
    logic cmp;
    logic y_zero;
  } stat_t;

endpackage

@@ src/mer_in_if.sv @@
// ----------------------------------------------------------------------------
// mer_in_if: item channel into the ellipse rasterizer
// valid/ready handshake carrying op and the two semi-axes
// ----------------------------------------------------------------------------
interface mer_in_if #(
  parameter int AXIS_BITS = 8
) ();
  logic                 valid;
  logic                 ready;
  logic                 op;
  logic [AXIS_BITS-1:0] semi_axis_x;
  logic [AXIS_BITS-1:0] semi_axis_y;

  modport source (output valid, output op, output semi_axis_x, output semi_axis_y,
                  input ready);
  modport sink (input valid, input op, input semi_axis_x, input semi_axis_y,
                output ready);
endinterface

@@ src/mer_out_if.sv @@
// ----------------------------------------------------------------------------
// mer_out_if: point group channel out of the ellipse rasterizer
// valid/ready handshake carrying four coordinates and three flags
// ----------------------------------------------------------------------------
interface mer_out_if #(
  parameter int COORD_BITS = 12
) ();
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] x_right;
  logic signed [COORD_BITS-1:0] x_left;
  logic signed [COORD_BITS-1:0] y_lower;
  logic signed [COORD_BITS-1:0] y_upper;
  logic                         point_valid;
  logic                         last_point;
  logic                         in_region_two;

  modport source (output valid, output x_right, output x_left, output y_lower,
                  output y_upper, output point_valid, output last_point,
                  output in_region_two, input ready);
  modport sink (input valid, input x_right, input x_left, input y_lower,
                input y_upper, input point_valid, input last_point,
                input in_region_two, output ready);
endinterface

@@ src/mer_datapath.sv @@
// ----------------------------------------------------------------------------
// mer_datapath: arithmetic of the ellipse rasterizer
// shared multiplier with registered product, decision accumulator, offsets,
// center registers and the output register
// ----------------------------------------------------------------------------
module mer_datapath
  import mer_pkg::*;
#(
  parameter int AXIS_BITS  = 8,
  parameter int COORD_BITS = 12
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [CFG_IDX_W-1:0]         cfg_idx_i,
  input  logic [CENTER_W-1:0]          cfg_data_i,
  input  logic [AXIS_BITS-1:0]         semi_axis_x_i,
  input  logic [AXIS_BITS-1:0]         semi_axis_y_i,
  input  cmd_t                         cmd_i,
  output stat_t                        stat_o,
  output logic signed [COORD_BITS-1:0] x_right_o,
  output logic signed [COORD_BITS-1:0] x_left_o,
  output logic signed [COORD_BITS-1:0] y_lower_o,
  output logic signed [COORD_BITS-1:0] y_upper_o,
  output logic                         point_valid_o,
  output logic                         last_point_o,
  output logic                         in_region_two_o
);

  localparam int OW    = 2 * AXIS_BITS + 3;
  localparam int PW    = 2 * OW;
  localparam int DW    = 4 * AXIS_BITS + 8;
  localparam int SQ_W  = 2 * AXIS_BITS;
  localparam int SUM_W = COORD_BITS + AXIS_BITS + CENTER_W;

  localparam logic signed [OW-1:0] K1 = OW'(1);
  localparam logic signed [OW-1:0] K2 = OW'(2);
  localparam logic signed [OW-1:0] K3 = OW'(3);

  logic [AXIS_BITS-1:0] a_q, b_q, x_q, y_q;
  logic [SQ_W-1:0]      asq_q, bsq_q;
  logic signed [PW-1:0] prod_q, tmp_q;
  wb_sel_e              wb_q;
  logic signed [DW-1:0] d_q;
  logic                 cmp_q;
  logic [CENTER_W-1:0]  cx_q, cy_q;

  logic signed [OW-1:0] xs, ys, as_s, bs_s, asq_s, bsq_s, tmp_s, op_a, op_b;
  logic signed [DW-1:0] prod_ext, prod4, asq_ext, bsq_ext;
  logic                 cmp_d;
  logic [SUM_W-1:0]     cx_e, cy_e, x_e, y_e, sum_xr, sum_xl, sum_yl, sum_yu;

  // operand terms
  always_comb begin
    xs    = signed'({{(OW-AXIS_BITS){1'b0}}, x_q});
    ys    = signed'({{(OW-AXIS_BITS){1'b0}}, y_q});
    as_s  = signed'({{(OW-AXIS_BITS){1'b0}}, a_q});
    bs_s  = signed'({{(OW-AXIS_BITS){1'b0}}, b_q});
    asq_s = signed'({{(OW-SQ_W){1'b0}}, asq_q});
    bsq_s = signed'({{(OW-SQ_W){1'b0}}, bsq_q});
    tmp_s = tmp_q[OW-1:0];
    unique case (cmd_i.mul)
      MUL_AA:       begin op_a = as_s;  op_b = as_s;               end
      MUL_BB:       begin op_a = bs_s;  op_b = bs_s;               end
      MUL_ASQ_B:    begin op_a = asq_s; op_b = bs_s;               end
      MUL_ASQ_2YM1: begin op_a = asq_s; op_b = (ys <<< 1) - K1;    end
      MUL_BSQ_XP1:  begin op_a = bsq_s; op_b = xs + K1;            end
      MUL_BSQ_2XP3: begin op_a = bsq_s; op_b = (xs <<< 1) + K3;    end
      MUL_ASQ_2M2Y: begin op_a = asq_s; op_b = K2 - (ys <<< 1);    end
      MUL_2XP1_SQ:  begin op_a = (xs <<< 1) + K1; op_b = (xs <<< 1) + K1; end
      MUL_BSQ_TMP:  begin op_a = bsq_s; op_b = tmp_s;              end
      MUL_YM1_SQ:   begin op_a = ys - K1; op_b = ys - K1;          end
      MUL_ASQ_TMP:  begin op_a = asq_s; op_b = tmp_s;              end
      MUL_ASQ_BSQ:  begin op_a = asq_s; op_b = bsq_s;              end
      MUL_BSQ_2XP2: begin op_a = bsq_s; op_b = (xs <<< 1) + K2;    end
      MUL_ASQ_3M2Y: begin op_a = asq_s; op_b = K3 - (ys <<< 1);    end
      default:      begin op_a = '0;    op_b = '0;                 end
    endcase
  end

  always_comb begin
    prod_ext = {{(DW-PW){prod_q[PW-1]}}, prod_q};
    prod4    = prod_ext <<< 2;
    asq_ext  = signed'({{(DW-SQ_W){1'b0}}, asq_q});
    bsq_ext  = signed'({{(DW-SQ_W){1'b0}}, bsq_q});
    // a^2(2y-1) against 2 b^2(x+1)
    cmp_d    = $signed({tmp_q[PW-1], tmp_q}) > $signed({prod_q, 1'b0});
  end

  assign stat_o.d_neg  = d_q[DW-1];
  assign stat_o.cmp    = cmp_q;
  assign stat_o.y_zero = (y_q == '0);

  // multiplier stage
  always_ff @(posedge clk_i) begin
    prod_q <= op_a * op_b;
  end

  // writeback of the registered product
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wb_q  <= WB_NONE;
      asq_q <= '0;
      bsq_q <= '0;
      d_q   <= '0;
      cmp_q <= 1'b0;
      tmp_q <= '0;
    end else begin
      wb_q <= cmd_i.wb;
      unique case (wb_q)
        WB_NONE:   ;
        WB_ASQ:    asq_q <= prod_q[SQ_W-1:0];
        WB_BSQ:    bsq_q <= prod_q[SQ_W-1:0];
        WB_TMP:    tmp_q <= prod_q;
        WB_CMP:    cmp_q <= cmp_d;
        WB_D_INIT: d_q   <= (bsq_ext <<< 2) + asq_ext - prod4;
        WB_D_LOAD: d_q   <= prod_ext;
        WB_D_ADD4: d_q   <= d_q + prod4;
        WB_D_SUB4: d_q   <= d_q - prod4;
        default:   ;
      endcase
    end
  end

  // axes, offsets and centers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_q  <= '0;
      b_q  <= '0;
      x_q  <= '0;
      y_q  <= '0;
      cx_q <= CENTER_X_RST;
      cy_q <= CENTER_Y_RST;
    end else begin
      if (cmd_i.load_axes) begin
        a_q <= semi_axis_x_i;
        b_q <= semi_axis_y_i;
      end
      if (cmd_i.init_offsets) begin
        x_q <= '0;
        y_q <= b_q;
      end else begin
        if (cmd_i.step_x) x_q <= x_q + 1'b1;
        if (cmd_i.step_y) y_q <= y_q - 1'b1;
      end
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_CENTER_X: cx_q <= cfg_data_i;
          CFG_CENTER_Y: cy_q <= cfg_data_i;
        endcase
      end
    end
  end

  always_comb begin
    cx_e   = SUM_W'(cx_q);
    cy_e   = SUM_W'(cy_q);
    x_e    = SUM_W'(x_q);
    y_e    = SUM_W'(y_q);
    sum_xr = cx_e + x_e;
    sum_xl = cx_e - x_e;
    sum_yl = cy_e + y_e;
    sum_yu = cy_e - y_e;
  end

  // output register
  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      if (cmd_i.emit_idle) begin
        x_right_o       <= '0;
        x_left_o        <= '0;
        y_lower_o       <= '0;
        y_upper_o       <= '0;
        point_valid_o   <= 1'b0;
        last_point_o    <= 1'b0;
        in_region_two_o <= 1'b0;
      end else begin
        x_right_o       <= signed'(sum_xr[COORD_BITS-1:0]);
        x_left_o        <= signed'(sum_xl[COORD_BITS-1:0]);
        y_lower_o       <= signed'(sum_yl[COORD_BITS-1:0]);
        y_upper_o       <= signed'(sum_yu[COORD_BITS-1:0]);
        point_valid_o   <= 1'b1;
        last_point_o    <= (y_q == '0);
        in_region_two_o <= cmd_i.emit_region;
      end
    end
  end

endmodule

@@ src/mer_ctrl.sv @@
// ----------------------------------------------------------------------------
// mer_ctrl: sequencer of the ellipse rasterizer
// issues multiplier and writeback commands per item, holds region, busy and
// the output valid flag
// ----------------------------------------------------------------------------
module mer_ctrl
  import mer_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  input  logic  in_op_i,
  output logic  in_ready_o,
  output logic  out_valid_o,
  input  logic  out_ready_i,
  input  stat_t stat_i,
  output cmd_t  cmd_o
);

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_START0,
    ST_START1,
    ST_START2,
    ST_R1_TEST0,
    ST_R1_TEST1,
    ST_R1_TEST2,
    ST_R1_STEP,
    ST_R1_STEP_B,
    ST_R2_INIT1,
    ST_R2_INIT2,
    ST_R2_INIT3,
    ST_R2_INIT4,
    ST_R2_INIT5,
    ST_R2_INIT6,
    ST_R2_INIT7,
    ST_R2_STEP,
    ST_R2_STEP_B,
    ST_FINISH,
    ST_EMIT
  } state_e;

  state_e state_q, state_d;
  logic   region_q, region_d;
  logic   busy_q, busy_d;
  logic   dneg_q, dneg_d;
  logic   idle_q, idle_d;
  logic   out_valid_q, out_valid_d;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;

  always_comb begin
    cmd_o       = '0;
    cmd_o.mul   = MUL_AA;
    cmd_o.wb    = WB_NONE;
    state_d     = state_q;
    region_d    = region_q;
    busy_d      = busy_q;
    dneg_d      = dneg_q;
    idle_d      = idle_q;
    out_valid_d = out_valid_q && !out_ready_i;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          idle_d = 1'b0;
          if (in_op_i == OP_START) begin
            cmd_o.load_axes = 1'b1;
            region_d        = 1'b0;
            state_d         = ST_START0;
          end else if (busy_q) begin
            state_d = region_q ? ST_R2_STEP : ST_R1_TEST0;
          end else begin
            idle_d  = 1'b1;
            state_d = ST_EMIT;
          end
        end
      end
      ST_START0: begin
        cmd_o.init_offsets = 1'b1;
        cmd_o.mul = MUL_AA;
        cmd_o.wb  = WB_ASQ;
        state_d   = ST_START1;
      end
      ST_START1: begin
        cmd_o.mul = MUL_BB;
        cmd_o.wb  = WB_BSQ;
        state_d   = ST_START2;
      end
      ST_START2: begin
        cmd_o.mul = MUL_ASQ_B;
        cmd_o.wb  = WB_D_INIT;
        state_d   = ST_EMIT;
      end
      ST_R1_TEST0: begin
        cmd_o.mul = MUL_ASQ_2YM1;
        cmd_o.wb  = WB_TMP;
        state_d   = ST_R1_TEST1;
      end
      ST_R1_TEST1: begin
        cmd_o.mul = MUL_BSQ_XP1;
        cmd_o.wb  = WB_CMP;
        state_d   = ST_R1_TEST2;
      end
      ST_R1_TEST2: begin
        state_d = ST_R1_STEP;
      end
      ST_R1_STEP: begin
        if (stat_i.cmp) begin
          dneg_d    = stat_i.d_neg;
          cmd_o.mul = MUL_BSQ_2XP3;
          cmd_o.wb  = WB_D_ADD4;
          state_d   = stat_i.d_neg ? ST_FINISH : ST_R1_STEP_B;
        end else begin
          region_d  = 1'b1;
          cmd_o.mul = MUL_2XP1_SQ;
          cmd_o.wb  = WB_TMP;
          state_d   = ST_R2_INIT1;
        end
      end
      ST_R1_STEP_B: begin
        cmd_o.mul = MUL_ASQ_2M2Y;
        cmd_o.wb  = WB_D_ADD4;
        state_d   = ST_FINISH;
      end
      ST_R2_INIT1: state_d = ST_R2_INIT2;
      ST_R2_INIT2: begin
        cmd_o.mul = MUL_BSQ_TMP;
        cmd_o.wb  = WB_D_LOAD;
        state_d   = ST_R2_INIT3;
      end
      ST_R2_INIT3: begin
        cmd_o.mul = MUL_YM1_SQ;
        cmd_o.wb  = WB_TMP;
        state_d   = ST_R2_INIT4;
      end
      ST_R2_INIT4: state_d = ST_R2_INIT5;
      ST_R2_INIT5: begin
        cmd_o.mul = MUL_ASQ_TMP;
        cmd_o.wb  = WB_D_ADD4;
        state_d   = ST_R2_INIT6;
      end
      ST_R2_INIT6: begin
        cmd_o.mul = MUL_ASQ_BSQ;
        cmd_o.wb  = WB_D_SUB4;
        state_d   = ST_R2_INIT7;
      end
      ST_R2_INIT7: state_d = ST_R2_STEP;
      ST_R2_STEP: begin
        dneg_d   = stat_i.d_neg;
        cmd_o.wb = WB_D_ADD4;
        if (stat_i.d_neg) begin
          cmd_o.mul = MUL_BSQ_2XP2;
          state_d   = ST_R2_STEP_B;
        end else begin
          cmd_o.mul = MUL_ASQ_3M2Y;
          state_d   = ST_FINISH;
        end
      end
      ST_R2_STEP_B: begin
        cmd_o.mul = MUL_ASQ_3M2Y;
        cmd_o.wb  = WB_D_ADD4;
        state_d   = ST_FINISH;
      end
      ST_FINISH: begin
        cmd_o.step_x = region_q ? dneg_q : 1'b1;
        cmd_o.step_y = region_q ? 1'b1 : !dneg_q;
        state_d      = ST_EMIT;
      end
      ST_EMIT: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.emit        = 1'b1;
          cmd_o.emit_idle   = idle_q;
          cmd_o.emit_region = region_q;
          out_valid_d       = 1'b1;
          if (!idle_q) busy_d = !stat_i.y_zero;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      region_q    <= 1'b0;
      busy_q      <= 1'b0;
      dneg_q      <= 1'b0;
      idle_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      region_q    <= region_d;
      busy_q      <= busy_d;
      dneg_q      <= dneg_d;
      idle_q      <= idle_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

@@ src/midpoint_ellipse_rasterizer.sv @@
// ----------------------------------------------------------------------------
// midpoint_ellipse_rasterizer: stepped midpoint ellipse point generator
// one point group of four symmetric pixels per item about a set center
// ----------------------------------------------------------------------------
// usage
//   cfg port: write center_x (index 0) and center_y (index 1) while idle;
//     reset loads 320 and 240
//   in_ch: op 0 starts an ellipse with semi-axes a and b and returns the
//     group at offset (0,b); op 1 advances one midpoint step and returns the
//     next group; an advance with no ellipse running returns an all-zero item
//   out_ch: exactly one item per input item, in order; last_point marks y = 0
// timing
//   one item at a time; ready is high only in the idle state
//   the schedule comes from the single shared multiplier: every product goes
//   into a product register and is then written back, and the region two
//   start needs two chained squares
// stall
//   a finished item sits in the output register; the next item may be accepted
//   and worked on, and its result waits in the emit state until out_ch drains
// reset: asynchronous active low, clears the sequencer and all ellipse state
// ----------------------------------------------------------------------------
module midpoint_ellipse_rasterizer
  import mer_pkg::*;
#(
  parameter int AXIS_BITS  = 8,
  parameter int COORD_BITS = 12
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CENTER_W-1:0]  cfg_data_i,
  mer_in_if.sink               in_ch,
  mer_out_if.source            out_ch
);

  // command and status between sequencer and datapath
  cmd_t  cmd;
  stat_t stat;

  // sequencer: walks the multiply/writeback schedule of each item
  mer_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_ch.valid),
    .in_op_i     (in_ch.op),
    .in_ready_o  (in_ch.ready),
    .out_valid_o (out_ch.valid),
    .out_ready_i (out_ch.ready),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  // datapath: multiplier, decision value, offsets, centers, output register
  mer_datapath #(
    .AXIS_BITS  (AXIS_BITS),
    .COORD_BITS (COORD_BITS)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_data_i      (cfg_data_i),
    .semi_axis_x_i   (in_ch.semi_axis_x),
    .semi_axis_y_i   (in_ch.semi_axis_y),
    .cmd_i           (cmd),
    .stat_o          (stat),
    .x_right_o       (out_ch.x_right),
    .x_left_o        (out_ch.x_left),
    .y_lower_o       (out_ch.y_lower),
    .y_upper_o       (out_ch.y_upper),
    .point_valid_o   (out_ch.point_valid),
    .last_point_o    (out_ch.last_point),
    .in_region_two_o (out_ch.in_region_two)
  );

  // the block is not ready again in the cycle after it accepts an item
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ch.valid && in_ch.ready |=> !in_ch.ready)
    else $error("input accepted twice in a row");

  // the last group of an ellipse is always a real point group
  a_last_is_point: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_ch.valid && out_ch.last_point |-> out_ch.point_valid)
    else $error("last_point without point_valid");

  // an idle advance returns all-zero fields
  a_idle_item_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_ch.valid && !out_ch.point_valid |-> out_ch.x_right == '0 &&
    out_ch.x_left == '0 && out_ch.y_lower == '0 && out_ch.y_upper == '0 &&
    !out_ch.in_region_two)
    else $error("non-zero fields on idle item");

  // the result register is never overwritten while a result is waiting
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(out_ch.x_right) &&
    $stable(out_ch.y_lower))
    else $error("waiting result overwritten");

endmodule
